// ----- hw/rtl/stack_pattern_removal_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stack pattern removal block
// Shared forms for concurrent checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef STACK_PATTERN_REMOVAL_TOP_DEFINES_SVH
`define STACK_PATTERN_REMOVAL_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack pattern removal package
// Item types, operation codes and register indexes shared by the block.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int FUNC_W    = 2;
	localparam int IDX_W     = 10;
	localparam int KL_W      = 11;
	localparam int LEN_W     = 5;
	localparam int PAT_BYTES = 16;
	localparam int PIDX_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [7:0]        text_byte;
		logic [IDX_W-1:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [KL_W-1:0] kept_length;
		logic            match_removed;
		logic [7:0]      read_byte;
		logic            overflow;
	} rsp_t;

	typedef logic [PAT_BYTES-1:0][7:0] pat_t;

	typedef struct packed {
		logic rd_en;
		logic done;
		logic match;
	} cmp_status_t;

endpackage

// ----- hw/rtl/stack_pattern_removal_top.sv -----
// ----------------------------------------------------------------------------
// Stack pattern removal, top level
// A push that reaches the pattern length is compared with the top of the stack
// before its result goes valid; the comparator reads one stack byte per cycle
// from the single RAM read port. A new item is taken only after the result of
// the last one has been loaded.
// Reset empties the stack, sets pattern_length to 1 and clears the pattern.
// ----------------------------------------------------------------------------
module stack_pattern_removal_top import spr_pkg::*; #(
	parameter int STACK_DEPTH = 1024,
	parameter int PATTERN_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int RW     = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_RDWAIT = 3'd2;
	localparam logic [2:0] ST_CMP    = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [LEN_W-1:0] plen_q;
	logic [CFG_W-1:0] pat_lo_q;
	logic [CFG_W-1:0] pat_hi_q;
	req_t             req_q;
	logic             removed_q;
	logic             ovf_q;
	logic [7:0]       rbyte_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [LEN_W-1:0]  len_eff;
	logic              full;
	logic [CNT_W-1:0]  cnt_inc;
	logic              can_cmp;
	logic              rd_hit;
	logic              rsp_load;
	logic              ram_wr_en;
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [7:0]        ram_rd_data;
	logic              cmp_start;
	logic [ADDR_W-1:0] cmp_base;
	logic [ADDR_W-1:0] cmp_addr;
	cmp_status_t       cmp_st;
	pat_t              pattern;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;
	assign pattern   = {pat_hi_q, pat_lo_q};

	assign len_eff = (plen_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : plen_q;
	assign full    = (count_q >= CNT_W'(STACK_DEPTH));
	assign cnt_inc = count_q + CNT_W'(1);
	assign can_cmp = (len_eff != '0) && (cnt_inc >= CNT_W'(len_eff));
	assign rd_hit  = (RW'(req_q.read_index) < RW'(count_q));

	assign ram_wr_en = (state_q == ST_EXEC) && (req_q.func == FUNC_PUSH) && !full;
	assign cmp_start = ram_wr_en && can_cmp;
	assign cmp_base  = ADDR_W'(cnt_inc - CNT_W'(len_eff));

	assign ram_rd_en = cmp_st.rd_en ||
		((state_q == ST_EXEC) && (req_q.func == FUNC_READ) && rd_hit);
	assign ram_rd_addr = cmp_st.rd_en ? cmp_addr : ADDR_W'(req_q.read_index);

	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || !rsp_stall);

	spr_ram #(
		.WIDTH(8),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ADDR_W'(count_q)),
		.wr_data(req_q.text_byte),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	spr_cmp #(
		.ADDR_W(ADDR_W)
	) u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmp_start),
		.base   (cmp_base),
		.len    (len_eff),
		.pattern(pattern),
		.rd_addr(cmp_addr),
		.rd_data(ram_rd_data),
		.status (cmp_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			plen_q      <= LEN_W'(1);
			pat_lo_q    <= '0;
			pat_hi_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PAT_LEN: plen_q   <= cfg_data[LEN_W-1:0];
					CFG_PAT_LO:  pat_lo_q <= cfg_data;
					CFG_PAT_HI:  pat_hi_q <= cfg_data;
					default: ;
				endcase
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (req_q.func)
						FUNC_CLEAR: begin
							count_q <= '0;
							state_q <= ST_RESULT;
						end
						FUNC_PUSH: begin
							if (full) begin
								state_q <= ST_RESULT;
							end else begin
								count_q <= cnt_inc;
								state_q <= can_cmp ? ST_CMP : ST_RESULT;
							end
						end
						FUNC_READ: state_q <= rd_hit ? ST_RDWAIT : ST_RESULT;
						default:   state_q <= ST_RESULT;
					endcase
				end
				ST_RDWAIT: state_q <= ST_RESULT;
				ST_CMP: begin
					if (cmp_st.done) begin
						if (cmp_st.match) begin
							count_q <= count_q - CNT_W'(len_eff);
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item and result fields; the state register and the result valid flag qualify them.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q     <= req;
				removed_q <= 1'b0;
				ovf_q     <= 1'b0;
				rbyte_q   <= '0;
			end
			ST_EXEC: begin
				if ((req_q.func == FUNC_PUSH) && full) begin
					ovf_q <= 1'b1;
				end
			end
			ST_RDWAIT: rbyte_q <= ram_rd_data;
			ST_CMP: begin
				if (cmp_st.done && cmp_st.match) begin
					removed_q <= 1'b1;
				end
			end
			default: ;
		endcase

		if (rsp_load) begin
			rsp_q.kept_length   <= KL_W'(count_q);
			rsp_q.match_removed <= removed_q;
			rsp_q.read_byte     <= rbyte_q;
			rsp_q.overflow      <= ovf_q;
		end
	end

endmodule

// ----- hw/rtl/spr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/spr_cmp.sv -----
// ----------------------------------------------------------------------------
// Stack pattern removal byte comparator
// Walks the top of the stack one byte per cycle against the pattern.
// ----------------------------------------------------------------------------
module spr_cmp import spr_pkg::*; #(
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] base,
	input  logic [LEN_W-1:0]  len,
	input  pat_t              pattern,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output cmp_status_t       status
);

	logic              run_q;
	logic [PIDX_W-1:0] idx_q;
	logic [ADDR_W-1:0] base_q;
	logic [LEN_W-1:0]  len_q;
	logic              ok_q;
	logic              vld_s1;
	logic              last_s1;
	logic [PIDX_W-1:0] pidx_s1;
	logic              issue_last;
	logic              eq;

	assign issue_last = (idx_q == PIDX_W'(len_q - LEN_W'(1)));
	assign rd_addr    = base_q + ADDR_W'(idx_q);
	// Read data arrives in the cycle after the address, so the compare lags the issue.
	assign eq         = (rd_data == pattern[pidx_s1]);

	assign status.rd_en = run_q;
	assign status.done  = vld_s1 && last_s1;
	assign status.match = ok_q && eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			ok_q   <= 1'b1;
		end else begin
			vld_s1 <= run_q;
			if (start) begin
				run_q <= 1'b1;
				ok_q  <= 1'b1;
			end else begin
				if (run_q && issue_last) begin
					run_q <= 1'b0;
				end
				if (vld_s1 && !eq) begin
					ok_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= issue_last;
		pidx_s1 <= idx_q;
		if (start) begin
			idx_q  <= '0;
			base_q <= base;
			len_q  <= len;
		end else if (run_q) begin
			idx_q <= idx_q + PIDX_W'(1);
		end
	end

endmodule

// ----- hw/rtl/spr_checker.sv -----
// ----------------------------------------------------------------------------
// Stack pattern removal port checker
// Watches the top level's channels and flags results that cannot occur.
// ----------------------------------------------------------------------------
`include "stack_pattern_removal_top_defines.svh"

module spr_checker import spr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled result stays presented and unchanged.
	`SPR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

	// The block works on one item at a time, so it is busy right after an accept.
	`SPR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall, "item accepted while still busy")

	// A dropped push compares nothing and so cannot remove a pattern.
	`SPR_ASSERT_SAME(a_ovf_no_match, clk, arst_n, rsp_valid, !(rsp.overflow && rsp.match_removed), "overflow and match reported together")

	// Only a read item returns a byte, and it carries no push flags.
	`SPR_ASSERT_SAME(a_read_only, clk, arst_n, rsp_valid && (rsp.read_byte != 8'd0), !rsp.match_removed && !rsp.overflow, "read byte reported with push flags")

endmodule

bind stack_pattern_removal_top spr_checker u_spr_checker (.*);
